/* hdl/mts_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the min-tracking stack.
package mts_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int DATA_W          = 32;

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP  = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
	localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

	typedef struct packed {
		logic do_push;   // write the pushed value and advance the tops
		logic do_pop;    // drop the top and fetch the entries below
		logic refresh;   // load the fetched entries into the top registers
		logic load_out;  // capture the result fields
	} mts_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mts_status_t;

endpackage

/* hdl/mts_ctrl.sv */
// Controller state machine of the min-tracking stack: handshakes, sequencing and status code.
module mts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	input  mts_pkg::mts_status_t dp_status,
	output mts_pkg::mts_cmd_t   dp_cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FINISH
	} state_t;

	state_t     state_q;
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [1:0] pend_status_q;
	logic       accept;
	logic       load_res;
	logic [1:0] status_d;
	logic       pop_ok;

	// A waiting result does not block the input: the next item is taken in and
	// held in the finish state until the result register frees up.
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_res  = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_comb begin
		status_d = mts_pkg::STATUS_OK;
		pop_ok   = 1'b0;
		unique case (func)
			mts_pkg::FUNC_PUSH: begin
				if (dp_status.full) begin
					status_d = mts_pkg::STATUS_PUSH_FULL;
				end
			end
			mts_pkg::FUNC_POP: begin
				if (dp_status.empty) begin
					status_d = mts_pkg::STATUS_POP_EMPTY;
				end else begin
					pop_ok = 1'b1;
				end
			end
			default: begin
				status_d = mts_pkg::STATUS_OK;
			end
		endcase
	end

	always_comb begin
		dp_cmd.do_push  = accept && (func == mts_pkg::FUNC_PUSH) && !dp_status.full;
		dp_cmd.do_pop   = accept && pop_ok;
		dp_cmd.refresh  = (state_q == S_READ);
		dp_cmd.load_out = load_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			status_q      <= mts_pkg::STATUS_OK;
			pend_status_q <= mts_pkg::STATUS_OK;
		end else begin
			if (load_res) begin
				out_valid_q <= 1'b1;
				status_q    <= pend_status_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_status_q <= status_d;
						state_q       <= pop_ok ? S_READ : S_FINISH;
					end
				end
				S_READ: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (load_res) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/mts_datapath.sv */
// Datapath of the min-tracking stack: value and minimum memories, counts, cached tops, results.
module mts_datapath #(
	parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mts_pkg::mts_cmd_t                 dp_cmd,
	output mts_pkg::mts_status_t              dp_status,
	input  logic signed [mts_pkg::DATA_W-1:0] push_value,
	output logic signed [mts_pkg::DATA_W-1:0] top_value,
	output logic signed [mts_pkg::DATA_W-1:0] min_value,
	output logic                              is_empty
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE        = CW'(1);

	logic signed [mts_pkg::DATA_W-1:0] value_mem [STACK_DEPTH];
	logic signed [mts_pkg::DATA_W-1:0] min_mem   [STACK_DEPTH];

	logic [CW-1:0] vcount_q;
	logic [CW-1:0] mcount_q;
	logic signed [mts_pkg::DATA_W-1:0] top_q;
	logic signed [mts_pkg::DATA_W-1:0] mtop_q;
	logic signed [mts_pkg::DATA_W-1:0] vrd_q;
	logic signed [mts_pkg::DATA_W-1:0] mrd_q;
	logic signed [mts_pkg::DATA_W-1:0] top_value_q;
	logic signed [mts_pkg::DATA_W-1:0] min_value_q;
	logic                              is_empty_q;

	logic          min_take;
	logic          min_drop;
	logic [CW-1:0] vcount_pop;
	logic [CW-1:0] mcount_pop;
	logic [AW-1:0] vrd_addr;
	logic [AW-1:0] mrd_addr;

	always_comb begin
		dp_status.full  = (vcount_q == FULL_COUNT);
		dp_status.empty = (vcount_q == '0);
		min_take   = ((mcount_q == '0) || (push_value <= mtop_q)) && (mcount_q != FULL_COUNT);
		min_drop   = (mcount_q != '0) && (top_q == mtop_q);
		vcount_pop = vcount_q - ONE;
		mcount_pop = min_drop ? (mcount_q - ONE) : mcount_q;
		// The entries that become the tops after a pop sit one below the new counts.
		vrd_addr   = (vcount_pop != '0) ? AW'(vcount_pop - ONE) : '0;
		mrd_addr   = (mcount_pop != '0) ? AW'(mcount_pop - ONE) : '0;
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.do_push) begin
			value_mem[vcount_q[AW-1:0]] <= push_value;
			if (min_take) begin
				min_mem[mcount_q[AW-1:0]] <= push_value;
			end
		end
		vrd_q <= value_mem[vrd_addr];
		mrd_q <= min_mem[mrd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			mcount_q <= '0;
		end else if (dp_cmd.do_push) begin
			vcount_q <= vcount_q + ONE;
			if (min_take) begin
				mcount_q <= mcount_q + ONE;
			end
		end else if (dp_cmd.do_pop) begin
			vcount_q <= vcount_pop;
			mcount_q <= mcount_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.do_push) begin
			top_q <= push_value;
			if (min_take) begin
				mtop_q <= push_value;
			end
		end else if (dp_cmd.refresh) begin
			top_q  <= vrd_q;
			mtop_q <= mrd_q;
		end
		if (dp_cmd.load_out) begin
			top_value_q <= dp_status.empty ? '0 : top_q;
			min_value_q <= (dp_status.empty || (mcount_q == '0)) ? '0 : mtop_q;
			is_empty_q  <= dp_status.empty;
		end
	end

	assign top_value = top_value_q;
	assign min_value = min_value_q;
	assign is_empty  = is_empty_q;

endmodule

/* hdl/min_tracking_stack_core.sv */
// Top level of the min-tracking stack: controller and datapath joined by command and status.
// A push, a peek or a refused operation goes from acceptance straight to the finish step;
// an accepted pop first passes a read step for the registered memory read of the new tops.
// No item is taken in until the last one is through; a result left waiting holds the
// following item in its last step, so only one more item is taken in before the input stalls.
// Reset (arst_n low, asynchronous) empties both stacks and drops any pending result.
module min_tracking_stack_core #(
	parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic signed [mts_pkg::DATA_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mts_pkg::DATA_W-1:0] top_value,
	output logic signed [mts_pkg::DATA_W-1:0] min_value,
	output logic                              is_empty,
	output logic [1:0]                        status
);

	// The controller judges each item against the full and empty flags, then steers the datapath:
	// a push writes the value memory and updates the cached tops in the same cycle (the minimum
	// side only for a value not above the minimum); a pop fetches the entries of the new tops.
	// The memories themselves are never cleared; only entries below the counts are read.
	mts_pkg::mts_cmd_t    dp_cmd;
	mts_pkg::mts_status_t dp_status;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	// The datapath keeps the top of each stack in a register so results never
	// wait on a memory read except right after a pop.
	mts_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.dp_status  (dp_status),
		.push_value (push_value),
		.top_value  (top_value),
		.min_value  (min_value),
		.is_empty   (is_empty)
	);

endmodule

/* hdl/mts_checker.sv */
// Port-level checks of the min-tracking stack and their binding to the top level.
module mts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [mts_pkg::DATA_W-1:0] top_value,
	input logic signed [mts_pkg::DATA_W-1:0] min_value,
	input logic                              is_empty,
	input logic [1:0]                        status
);

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (top_value == '0) && (min_value == '0))
		else $error("empty result carries nonzero top or minimum");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty |-> (min_value <= top_value))
		else $error("minimum exceeds top value");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mts_pkg::STATUS_POP_EMPTY) |-> is_empty)
		else $error("refused pop on a stack that is not empty");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mts_pkg::STATUS_PUSH_FULL) |-> !is_empty)
		else $error("refused push on an empty stack");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(status))
		else $error("stalled result changed");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.top_value (top_value),
	.min_value (min_value),
	.is_empty  (is_empty),
	.status    (status)
);
